### rtl/register_access_mask_table_macros.svh
// Assertion macros shared by the register access mask table checkers.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef REGISTER_ACCESS_MASK_TABLE_MACROS_SVH
`define REGISTER_ACCESS_MASK_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAMT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RAMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ramt_pkg.sv
// Types and constants of the register access mask table.
// Used by the controller, the datapath, the top level and the checker.
package ramt_pkg;

  localparam int ADDR_W      = 64;
  localparam int MASK_W      = 64;
  localparam int INDEX_W     = 6;
  localparam int COUNT_OUT_W = 7;
  localparam int IN_DATA_W   = 200;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 200;
  localparam int OUT_USER_W  = 3;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    RES_EMPTY = 3'd0,
    RES_DUP   = 3'd1,
    RES_FULL  = 3'd2,
    RES_MATCH = 3'd3,
    RES_ENTRY = 3'd4
  } result_kind_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [MASK_W-1:0] write_mask;
    logic [MASK_W-1:0] read_mask;
  } entry_t;

  typedef struct packed {
    logic         load_item;
    logic         ptr_inc;
    logic         mem_read;
    logic         read_by_index;
    logic         mem_write;
    logic         count_clear;
    logic         count_inc;
    logic         out_load;
    result_kind_t out_kind;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    match;
    logic    scan_last;
    logic    scan_empty;
    logic    full;
    logic    index_valid;
    logic    out_free;
  } dp_status_t;

endpackage

### rtl/ramt_ctrl.sv
// Controller state machine of the register access mask table.
// Depends on ramt_pkg; drives the datapath through dp_cmd_t.
module ramt_ctrl
  import ramt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_DECODE    = 6'b000010,
    S_SCAN_RD   = 6'b000100,
    S_SCAN_CMP  = 6'b001000,
    S_READ_RD   = 6'b010000,
    S_READ_DATA = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // Completion of an insert or lookup whose address is not in the table.
  function automatic dp_cmd_t finish_miss(opcode_t op, logic full);
    dp_cmd_t c;
    c = '0;
    c.out_load = 1'b1;
    c.out_kind = RES_EMPTY;
    if (op == OP_INSERT) begin
      if (full) begin
        c.out_kind = RES_FULL;
      end else begin
        c.mem_write = 1'b1;
        c.count_inc = 1'b1;
      end
    end
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.out_kind = RES_EMPTY;
    s_tready     = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status.opcode)
          OP_CLEAR: begin
            if (status.out_free) begin
              cmd.count_clear = 1'b1;
              cmd.out_load    = 1'b1;
              state_next      = S_IDLE;
            end
          end
          OP_INSERT, OP_LOOKUP: begin
            if (status.scan_empty) begin
              if (status.out_free) begin
                cmd        = finish_miss(status.opcode, status.full);
                state_next = S_IDLE;
              end
            end else begin
              state_next = S_SCAN_RD;
            end
          end
          OP_READ: begin
            if (status.index_valid) begin
              state_next = S_READ_RD;
            end else if (status.out_free) begin
              cmd.out_load = 1'b1;
              state_next   = S_IDLE;
            end
          end
        endcase
      end
      S_SCAN_RD: begin
        cmd.mem_read = 1'b1;
        state_next   = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (status.match) begin
          if (status.out_free) begin
            cmd.out_load = 1'b1;
            if (status.opcode == OP_INSERT) begin
              cmd.count_clear = 1'b1;
              cmd.out_kind    = RES_DUP;
            end else begin
              cmd.out_kind = RES_MATCH;
            end
            state_next = S_IDLE;
          end
        end else if (status.scan_last) begin
          if (status.out_free) begin
            cmd        = finish_miss(status.opcode, status.full);
            state_next = S_IDLE;
          end
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_READ_RD: begin
        cmd.mem_read      = 1'b1;
        cmd.read_by_index = 1'b1;
        state_next        = S_READ_DATA;
      end
      S_READ_DATA: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = RES_ENTRY;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/ramt_datapath.sv
// Datapath of the register access mask table: item register, entry memory,
// scan pointer, entry count and output register. Depends on ramt_pkg.
module ramt_datapath
  import ramt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [OUT_USER_W-1:0] m_tuser,
  input  dp_cmd_t               cmd,
  output dp_status_t            status
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  opcode_t            item_opcode;
  logic [ADDR_W-1:0]  item_address;
  logic [MASK_W-1:0]  item_write_mask;
  logic [MASK_W-1:0]  item_read_mask;
  logic [INDEX_W-1:0] item_index;

  logic [CW-1:0] ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [IW-1:0] read_addr;

  entry_t mem [TABLE_ENTRIES];
  entry_t rdata;
  entry_t wdata;

  logic                   hit_next;
  logic [MASK_W-1:0]      read_mask_next;
  logic [MASK_W-1:0]      write_mask_next;
  logic [ADDR_W-1:0]      entry_address_next;
  status_t                status_next;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_opcode     <= opcode_t'(s_tuser[1:0]);
      item_address    <= s_tdata[63:0];
      item_write_mask <= s_tdata[127:64];
      item_read_mask  <= s_tdata[191:128];
      item_index      <= s_tdata[197:192];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.load_item) begin
      ptr <= '0;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + CW'(1);
    end
  end

  always_comb begin
    priority if (cmd.count_clear) begin
      count_next = '0;
    end else if (cmd.count_inc) begin
      count_next = count + CW'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign read_addr = cmd.read_by_index ? IW'(item_index) : ptr[IW-1:0];
  assign wdata     = '{address: item_address, write_mask: item_write_mask,
                       read_mask: item_read_mask};

  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      mem[count[IW-1:0]] <= wdata;
    end
    if (cmd.mem_read) begin
      rdata <= mem[read_addr];
    end
  end

  assign status.opcode      = item_opcode;
  assign status.match       = (rdata.address == item_address);
  assign status.scan_last   = ((ptr + CW'(1)) == count);
  assign status.scan_empty  = (count == '0);
  assign status.full        = (count == CW'(TABLE_ENTRIES));
  assign status.index_valid = (32'(item_index) < 32'(count));
  assign status.out_free    = !m_tvalid || m_tready;

  always_comb begin
    hit_next           = 1'b0;
    read_mask_next     = '0;
    write_mask_next    = '0;
    entry_address_next = '0;
    status_next        = ST_OK;
    unique case (cmd.out_kind)
      RES_EMPTY: begin
      end
      RES_DUP: begin
        status_next = ST_DUP;
      end
      RES_FULL: begin
        status_next = ST_FULL;
      end
      RES_MATCH: begin
        hit_next        = 1'b1;
        read_mask_next  = rdata.read_mask;
        write_mask_next = rdata.write_mask;
      end
      RES_ENTRY: begin
        hit_next           = 1'b1;
        read_mask_next     = rdata.read_mask;
        write_mask_next    = rdata.write_mask;
        entry_address_next = rdata.address;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {1'b0, COUNT_OUT_W'(count_next), entry_address_next,
                  write_mask_next, read_mask_next};
      m_tuser <= {status_next, hit_next};
    end
  end

endmodule

### rtl/register_access_mask_table.sv
// Top level of the register access mask table.
// Depends on ramt_pkg, ramt_ctrl and ramt_datapath.
//
// Channel   Direction  Transaction
// s_*       input      one operation: opcode, address, masks, entry index
// m_*       output     one result: hit, masks, entry address, status, count
//
// Clear completes in the decode state, as does readback of an invalid index;
// a valid readback passes a memory read and a data state. Insert and lookup
// pass a read and a compare state per entry scanned (at most the entry count):
// the single read port of the entry memory is probed one entry at a time.
// Reset empties the table and the output register at once; no clearing pass.
// A result held by m_tready low stalls only the completion of the next item.
module register_access_mask_table
  import ramt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // msr_address[63:0], write_mask_in[127:64], read_mask_in[191:128],
  // entry_index[197:192], zero padding above.
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // opcode[1:0].
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // read_mask[63:0], write_mask[127:64], entry_address[191:128],
  // entry_count[198:192], zero padding above.
  output logic [OUT_DATA_W-1:0] m_tdata,
  // hit[0], status[2:1].
  output logic [OUT_USER_W-1:0] m_tuser
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ramt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ramt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

### rtl/ramt_checker.sv
// Port-level checker of the register access mask table and its bind.
// Depends on ramt_pkg and register_access_mask_table_macros.svh.
`include "register_access_mask_table_macros.svh"

module ramt_checker
  import ramt_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic [IN_USER_W-1:0]  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [OUT_USER_W-1:0] m_tuser
);

  `RAMT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `RAMT_ASSERT_SAME(a_hit_status, m_tvalid && m_tuser[0], m_tuser[2:1] == ST_OK, "hit with error status")
  `RAMT_ASSERT_SAME(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata[191:0] == '0, "miss with nonzero data")
  `RAMT_ASSERT_SAME(a_dup_empty, m_tvalid && (m_tuser[2:1] == ST_DUP), m_tdata[198:192] == '0, "duplicate left entries")

endmodule

bind register_access_mask_table ramt_checker u_checker (.*);

### tb/tb.sv
// Self-checking testbench for register_access_mask_table: drives clear, insert,
// lookup and readback transactions and compares each result with a predictor.
// Depends on ramt_pkg and the register_access_mask_table RTL.
`timescale 1ns / 1ps

module tb;
  import ramt_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 150;

  typedef struct packed {
    logic              hit;
    logic [MASK_W-1:0] read_mask;
    logic [MASK_W-1:0] write_mask;
    logic [ADDR_W-1:0] entry_address;
    status_t           status;
    logic [6:0]        count;
  } table_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [IN_USER_W-1:0]  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  logic [ADDR_W-1:0] table_addr [TABLE_ENTRIES];
  logic [MASK_W-1:0] table_wmask [TABLE_ENTRIES];
  logic [MASK_W-1:0] table_rmask [TABLE_ENTRIES];
  int                table_count;

  table_result_t pending_results [$];
  int            error_count;
  int            cycle_count;
  bit            idle_on;

  register_access_mask_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Updates the table copy for one accepted transaction and returns its result.
  function automatic table_result_t predict_table_op(input opcode_t op,
                                                     input logic [63:0] addr,
                                                     input logic [63:0] wmask,
                                                     input logic [63:0] rmask,
                                                     input logic [5:0] idx);
    table_result_t r;
    int pos;
    r = '0;
    pos = -1;
    for (int i = 0; i < table_count; i++) begin
      if (pos < 0 && table_addr[i] == addr) pos = i;
    end
    case (op)
      OP_CLEAR: begin
        table_count = 0;
      end
      OP_INSERT: begin
        if (pos >= 0) begin
          table_count = 0;
          r.status = ST_DUP;
        end else if (table_count >= TABLE_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          table_addr[table_count] = addr;
          table_wmask[table_count] = wmask;
          table_rmask[table_count] = rmask;
          table_count++;
        end
      end
      OP_LOOKUP: begin
        if (pos >= 0) begin
          r.hit = 1'b1;
          r.read_mask = table_rmask[pos];
          r.write_mask = table_wmask[pos];
        end
      end
      default: begin
        if (idx < table_count) begin
          r.hit = 1'b1;
          r.read_mask = table_rmask[idx];
          r.write_mask = table_wmask[idx];
          r.entry_address = table_addr[idx];
        end
      end
    endcase
    r.count = table_count[6:0];
    return r;
  endfunction

  // Called and returns at a falling edge; the transaction is accepted in between.
  task automatic send_op(input opcode_t op, input logic [63:0] addr,
                         input logic [63:0] wmask, input logic [63:0] rmask,
                         input logic [5:0] idx);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = {2'b00, idx, rmask, wmask, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_table_op(op, addr, wmask, rmask, idx));
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic compare_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    table_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual tdata %h tuser %h",
                 $time, m_tdata, m_tuser);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        compare_field("hit", exp_res.hit, m_tuser[0]);
        compare_field("status", exp_res.status, m_tuser[2:1]);
        compare_field("read_mask", exp_res.read_mask, m_tdata[63:0]);
        compare_field("write_mask", exp_res.write_mask, m_tdata[127:64]);
        compare_field("entry_address", exp_res.entry_address, m_tdata[191:128]);
        compare_field("entry_count", exp_res.count, m_tdata[198:192]);
      end
    end
  end

  initial begin
    m_tready = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        m_tready = 1'b1;
      end
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  task automatic test_directed();
    logic [63:0] ones;
    ones = '1;
    send_op(OP_CLEAR, ones, ones, ones, 6'd63);
    send_op(OP_READ, '0, '0, '0, 6'd0);
    send_op(OP_LOOKUP, '0, '0, '0, 6'd0);
    send_op(OP_INSERT, '0, '0, '0, 6'd0);
    send_op(OP_INSERT, ones, ones, ones, 6'd63);
    send_op(OP_INSERT, 64'h5a5a_0000_ffff_00a5, 64'h5555_5555_5555_5555,
            64'haaaa_aaaa_aaaa_aaaa, 6'd0);
    send_op(OP_LOOKUP, '0, ones, ones, 6'd0);
    send_op(OP_LOOKUP, ones, '0, '0, 6'd0);
    send_op(OP_LOOKUP, 64'h0000_0000_0000_0123, '0, '0, 6'd0);
    send_op(OP_READ, '0, '0, '0, 6'd0);
    send_op(OP_READ, ones, ones, ones, 6'd1);
    send_op(OP_READ, '0, '0, '0, 6'd2);
    send_op(OP_READ, '0, '0, '0, 6'd3);
    send_op(OP_READ, '0, '0, '0, 6'd63);
    send_op(OP_INSERT, ones, 64'h1234, 64'h5678, 6'd0);
    send_op(OP_LOOKUP, ones, '0, '0, 6'd0);
    send_op(OP_READ, '0, '0, '0, 6'd0);
    send_op(OP_INSERT, 64'd1, random_word(), random_word(), 6'd0);
    send_op(OP_INSERT, 64'd2, random_word(), random_word(), 6'd0);
    send_op(OP_CLEAR, '0, '0, '0, 6'd0);
    send_op(OP_READ, '0, '0, '0, 6'd0);
    send_op(OP_LOOKUP, 64'd1, '0, '0, 6'd0);
  endtask

  task automatic test_fill_to_full();
    send_op(OP_CLEAR, random_word(), random_word(), random_word(), 6'($urandom));
    for (int i = 0; i < TABLE_ENTRIES + 2; i++) begin
      send_op(OP_INSERT, random_word(), random_word(), random_word(), 6'($urandom));
    end
    send_op(OP_READ, '0, '0, '0, 6'd63);
    send_op(OP_LOOKUP, table_addr[TABLE_ENTRIES-1], '0, '0, 6'd0);
    send_op(OP_LOOKUP, random_word(), '0, '0, 6'd0);
    wait_for_results();
    send_op(OP_INSERT, table_addr[TABLE_ENTRIES-1], random_word(), random_word(), 6'd0);
    send_op(OP_READ, '0, '0, '0, 6'd0);
  endtask

  task automatic test_random_mix(input int num_ops);
    int sel;
    logic [63:0] addr;
    logic [5:0] idx;
    for (int i = 0; i < num_ops; i++) begin
      sel = $urandom_range(0, 99);
      idx = 6'($urandom);
      addr = random_word();
      if (sel < 2) begin
        send_op(OP_CLEAR, addr, random_word(), random_word(), idx);
      end else if (sel < 45) begin
        send_op(OP_INSERT, addr, random_word(), random_word(), idx);
      end else if (sel < 48) begin
        if (table_count > 0) addr = table_addr[$urandom_range(0, table_count - 1)];
        send_op(OP_INSERT, addr, random_word(), random_word(), idx);
      end else if (sel < 74) begin
        if (table_count > 0 && $urandom_range(0, 3) != 0) begin
          addr = table_addr[$urandom_range(0, table_count - 1)];
        end
        send_op(OP_LOOKUP, addr, random_word(), random_word(), idx);
      end else begin
        if (table_count > 0 && $urandom_range(0, 3) != 0) begin
          idx = 6'($urandom_range(0, table_count - 1));
        end
        send_op(OP_READ, addr, random_word(), random_word(), idx);
      end
    end
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    test_random_mix(100);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_CLEAR;
    table_count = 0;
    error_count = 0;
    cycle_count = 0;
    idle_on = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_fill_to_full();
    test_random_mix(460);
    test_full_rate();
    s_tvalid = 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
